### design/grms_pkg.sv
// Package for the greedy resource member selector: payload structs, codes, state enum.
// No dependencies.
package grms_pkg;

    localparam int unsigned DefMaxMembers = 32;
    localparam int unsigned TotalW = 37;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_UPDATE = 2'd2,
        OP_REQ    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_IGNORED = 2'd1,
        ST_NOALLOC = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] member_id;
        logic [31:0] member_type;
        logic [31:0] amount;
    } item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [31:0]       chosen_id;
        logic [31:0]       chosen_amount;
        logic [TotalW-1:0] running_total;
        logic              last;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_EMIT,
        S_DONE
    } state_t;

endpackage

### design/greedy_resource_member_selector.sv
// Top level of the greedy resource member selector: member table in a synchronous
// memory, scanned one slot a cycle. Depends on grms_pkg.
//
//  channel | signals                       | handshake
//  --------+-------------------------------+----------------------------------
//  item    | start, busy, item             | taken when start && !busy
//  result  | res_valid, res                | one-cycle strobe, cannot stall
//  config  | cfg_valid, cfg_ready, cfg_data| written when cfg_valid && cfg_ready
//
// Every item makes at least one pass over the table, through the single registered memory
// read port, to find its slot, free slot, eligible sum and the best untaken member. Add,
// remove, update and a request with no allocation then finish; a request that chooses
// n members repeats the pass per member. The next item is taken in the first cycle
// with busy low. Reset empties the table at once via per-slot valid flags. Results
// leave on a strobe; there is no back-pressure.
module greedy_resource_member_selector #(
    parameter int unsigned MAX_MEMBERS = grms_pkg::DefMaxMembers
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  grms_pkg::item_t   item,
    output logic              res_valid,
    output grms_pkg::result_t res,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [31:0]       cfg_data
);
    import grms_pkg::*;

    localparam int unsigned IW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
    localparam int unsigned CW = $clog2(MAX_MEMBERS + 1);
    localparam int unsigned SumW = 32 + CW;

    logic [31:0] mem_id [MAX_MEMBERS];
    logic [31:0] mem_amt [MAX_MEMBERS];
    logic [MAX_MEMBERS-1:0] valid_reg, valid_next;
    logic [MAX_MEMBERS-1:0] taken_reg, taken_next;

    state_t state_reg, state_next;
    item_t item_reg, item_next;
    logic [31:0] type_reg;
    logic [CW-1:0] addr_reg, addr_next;
    logic [IW-1:0] rd_slot_reg;
    logic rd_live_reg;
    logic [31:0] rd_id, rd_amt;
    logic first_pass_reg, first_pass_next;
    logic found_reg, found_next;
    logic [IW-1:0] found_slot_reg, found_slot_next;
    logic free_ok_reg, free_ok_next;
    logic [IW-1:0] free_slot_reg, free_slot_next;
    logic [SumW-1:0] sum_reg, sum_next;
    logic best_ok_reg, best_ok_next;
    logic [IW-1:0] best_slot_reg, best_slot_next;
    logic [31:0] best_id_reg, best_id_next, best_amt_reg, best_amt_next;
    logic [TotalW-1:0] total_reg, total_next;

    logic wr_en;
    logic [IW-1:0] wr_slot;
    logic [31:0] wr_id, wr_amt;
    logic rd_req;
    logic res_valid_next;
    result_t res_next;
    logic slot_valid, elig;

    assign cfg_ready = 1'b1;
    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            type_reg <= cfg_data;
        end
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_id[wr_slot]  <= wr_id;
            mem_amt[wr_slot] <= wr_amt;
        end
        rd_id       <= mem_id[addr_reg[IW-1:0]];
        rd_amt      <= mem_amt[addr_reg[IW-1:0]];
        rd_slot_reg <= addr_reg[IW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            taken_reg   <= '0;
            rd_live_reg <= 1'b0;
            res_valid   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            taken_reg   <= taken_next;
            rd_live_reg <= rd_req;
            res_valid   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        addr_reg       <= addr_next;
        first_pass_reg <= first_pass_next;
        found_reg      <= found_next;
        found_slot_reg <= found_slot_next;
        free_ok_reg    <= free_ok_next;
        free_slot_reg  <= free_slot_next;
        sum_reg        <= sum_next;
        best_ok_reg    <= best_ok_next;
        best_slot_reg  <= best_slot_next;
        best_id_reg    <= best_id_next;
        best_amt_reg   <= best_amt_next;
        total_reg      <= total_next;
        res            <= res_next;
    end

    assign slot_valid = valid_reg[rd_slot_reg];
    assign elig = slot_valid && (rd_id != item_reg.member_id) && (rd_amt != 32'd0)
                  && !taken_reg[rd_slot_reg];

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        addr_next       = addr_reg;
        first_pass_next = first_pass_reg;
        found_next      = found_reg;
        found_slot_next = found_slot_reg;
        free_ok_next    = free_ok_reg;
        free_slot_next  = free_slot_reg;
        sum_next        = sum_reg;
        best_ok_next    = best_ok_reg;
        best_slot_next  = best_slot_reg;
        best_id_next    = best_id_reg;
        best_amt_next   = best_amt_reg;
        total_next      = total_reg;
        valid_next      = valid_reg;
        taken_next      = taken_reg;
        wr_en           = 1'b0;
        wr_slot         = found_slot_reg;
        wr_id           = item_reg.member_id;
        wr_amt          = item_reg.amount;
        rd_req          = 1'b0;
        res_valid_next  = 1'b0;
        res_next        = '0;
        res_next.last   = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next       = item;
                    addr_next       = '0;
                    first_pass_next = 1'b1;
                    found_next      = 1'b0;
                    free_ok_next    = 1'b0;
                    sum_next        = '0;
                    best_ok_next    = 1'b0;
                    total_next      = '0;
                    taken_next      = '0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // Issue reads while the address is in range; fold in returned data.
                if (addr_reg < CW'(MAX_MEMBERS))
                begin
                    rd_req    = 1'b1;
                    addr_next = addr_reg + 1'b1;
                end
                if (rd_live_reg)
                begin
                    if (first_pass_reg)
                    begin
                        if (slot_valid && rd_id == item_reg.member_id && !found_reg)
                        begin
                            found_next      = 1'b1;
                            found_slot_next = rd_slot_reg;
                        end
                        if (!slot_valid && !free_ok_reg)
                        begin
                            free_ok_next   = 1'b1;
                            free_slot_next = rd_slot_reg;
                        end
                        if (elig)
                        begin
                            sum_next = sum_reg + SumW'(rd_amt);
                        end
                    end
                    if (elig && (!best_ok_reg || rd_amt > best_amt_reg ||
                        (rd_amt == best_amt_reg && rd_id < best_id_reg)))
                    begin
                        best_ok_next   = 1'b1;
                        best_slot_next = rd_slot_reg;
                        best_id_next   = rd_id;
                        best_amt_next  = rd_amt;
                    end
                end
                else if (addr_reg == CW'(MAX_MEMBERS))
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                res_valid_next = 1'b1;
                state_next     = S_DONE;
                case (op_t'(item_reg.opcode))
                    OP_ADD:
                    begin
                        if (item_reg.member_type != type_reg || found_reg)
                        begin
                            res_next.status = ST_IGNORED;
                        end
                        else if (!free_ok_reg)
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            res_next.status = ST_OK;
                            wr_en   = 1'b1;
                            wr_slot = free_slot_reg;
                            valid_next[free_slot_reg] = 1'b1;
                        end
                    end
                    OP_REMOVE:
                    begin
                        res_next.status = found_reg ? ST_OK : ST_IGNORED;
                        if (found_reg)
                        begin
                            valid_next[found_slot_reg] = 1'b0;
                        end
                    end
                    OP_UPDATE:
                    begin
                        res_next.status = found_reg ? ST_OK : ST_IGNORED;
                        // Rewrite the id alongside the new amount.
                        if (found_reg)
                        begin
                            wr_en = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (first_pass_reg &&
                            (!best_ok_reg || sum_reg < SumW'(item_reg.amount)))
                        begin
                            res_next.status = ST_NOALLOC;
                        end
                        else
                        begin
                            res_valid_next = 1'b0;
                            state_next     = S_EMIT;
                        end
                    end
                endcase
            end
            S_EMIT:
            begin
                // Emit the best member, then rescan unless the need is met.
                res_valid_next         = 1'b1;
                res_next.status        = ST_OK;
                res_next.chosen_id     = best_id_reg;
                res_next.chosen_amount = best_amt_reg;
                res_next.running_total = total_reg + TotalW'(best_amt_reg);
                res_next.last = (total_reg + TotalW'(best_amt_reg))
                                >= TotalW'(item_reg.amount);
                total_next = total_reg + TotalW'(best_amt_reg);
                taken_next[best_slot_reg] = 1'b1;
                if (res_next.last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    first_pass_next = 1'b0;
                    best_ok_next    = 1'b0;
                    addr_next       = '0;
                    state_next      = S_SCAN;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
